// ===== design/tmfd_pkg.sv =====
// ----------------------------------------------------------------------------
// tmfd_pkg
// Shared types, constants and the crc function of the telemetry frame
// deframer.
// ----------------------------------------------------------------------------
package tmfd_pkg;

  // frame geometry limits
  localparam int unsigned MaxFrameBytes = 2048;
  localparam int unsigned MaxShBytes    = 64;
  localparam int unsigned MinFrameBytes = 7;

  localparam int unsigned PosW    = $clog2(MaxFrameBytes);
  localparam int unsigned LenW    = 12;
  localparam int unsigned ShLenW  = 7;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 12;
  localparam int unsigned HdrBytes = 7;

  // crc-16 settings
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_FRAME_LENGTH  = 3'd0,
    CFG_FECF_ENABLE   = 3'd1,
    CFG_EXT_COUNT_EN  = 3'd2,
    CFG_FRAME_VERSION = 3'd3,
    CFG_SH_VERSION    = 3'd4
  } cfg_idx_e;

  // byte classes
  typedef enum logic [2:0] {
    CLS_PRIMARY   = 3'd0,
    CLS_SECONDARY = 3'd1,
    CLS_DATA      = 3'd2,
    CLS_OCF       = 3'd3,
    CLS_FECF      = 3'd4
  } class_e;

  // frame status codes, in priority order
  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_CRC         = 3'd1,
    ST_VERSION     = 3'd2,
    ST_SH_VERSION  = 3'd3,
    ST_SH_TOO_LONG = 3'd4,
    ST_EXT_LEN     = 3'd5,
    ST_EXT_NO_SH   = 3'd6,
    ST_TOO_SHORT   = 3'd7
  } status_e;

  // one result item
  typedef struct packed {
    logic [7:0]  byte_out;
    class_e      byte_class;
    logic        frame_end;
    status_e     status;
    logic [9:0]  spacecraft_id;
    logic [2:0]  channel_id;
    logic [7:0]  master_count;
    logic [31:0] channel_count;
    logic        sh_present;
    logic        byte_synchronised;
    logic [10:0] header_pointer;
    logic        ocf_present;
  } res_t;

  // crc-16 over one byte, msb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ b[i];
      r  = {r[14:0], 1'b0};
      if (fb) begin
        r = r ^ CrcPoly;
      end
    end
    return r;
  endfunction

endpackage

// ===== design/tm_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// tm_frame_deframer
// Byte-serial receiver for fixed-length telemetry transfer frames: tags each
// byte, checks crc and header rules, reports header fields on the last byte.
// ----------------------------------------------------------------------------
//  channel   signals                                   direction
//  input     in_valid_i, in_stall_o, frame_byte_i      byte in
//  output    out_valid_o, out_stall_i, result fields   one result per byte
//  config    cfg_we_i, cfg_idx_i, cfg_data_i           register write
//
//  One byte per cycle while in_stall_o is low; each result is registered, in the skid if output stalls.
//  The per-byte work (crc step, header capture, checks) is one layer of
//  logic between the frame state registers and the result register.
//  A skid register behind the result register keeps input going for one
//  more byte under output stall; in_stall_o rises only when the skid is full.
//  Reset clears position and header capture, sets crc to CrcInit and loads configuration defaults.
// ----------------------------------------------------------------------------
module tm_frame_deframer
  import tmfd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_data_i,
  // input bytes
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          frame_byte_i,
  // results
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          byte_out_o,
  output logic [2:0]          byte_class_o,
  output logic                frame_end_o,
  output logic [2:0]          status_o,
  output logic [9:0]          spacecraft_id_o,
  output logic [2:0]          channel_id_o,
  output logic [7:0]          master_count_o,
  output logic [31:0]         channel_count_o,
  output logic                sh_present_o,
  output logic                byte_synchronised_o,
  output logic [10:0]         header_pointer_o,
  output logic                ocf_present_o
);

  // configuration registers
  logic [LenW-1:0] frame_length_q;
  logic            fecf_enable_q;
  logic            ext_count_enable_q;
  logic [1:0]      exp_frame_version_q;
  logic [1:0]      exp_sh_version_q;

  // frame state
  logic [PosW-1:0]   pos_q, pos_d;
  logic [15:0]       crc_q, crc_d;
  logic [7:0]        hb_q [HdrBytes];
  logic [7:0]        hb_n [HdrBytes];
  logic [ShLenW-1:0] shl_q, shl_n;
  logic [23:0]       ext_q, ext_n;

  // output and skid registers
  res_t out_q, skid_q, res;
  logic out_valid_q, skid_valid_q;

  logic in_acc, out_take;

  // combinational per-byte work
  logic [LenW-1:0]   len, pos12, fecf2, ocf4, sub, max_diff, sh_used;
  logic [ShLenW-1:0] maxsh;
  logic              ocf, sh, last, sync;
  logic [15:0]       crc_n;
  status_e           st;

  assign in_acc   = in_valid_i && !skid_valid_q;
  assign out_take = out_valid_q && !out_stall_i;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_length_q      <= LenW'(1115);
      fecf_enable_q       <= 1'b0;
      ext_count_enable_q  <= 1'b0;
      exp_frame_version_q <= 2'd0;
      exp_sh_version_q    <= 2'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FRAME_LENGTH:  frame_length_q      <= cfg_data_i[LenW-1:0];
        CFG_FECF_ENABLE:   fecf_enable_q       <= cfg_data_i[0];
        CFG_EXT_COUNT_EN:  ext_count_enable_q  <= cfg_data_i[0];
        CFG_FRAME_VERSION: exp_frame_version_q <= cfg_data_i[1:0];
        CFG_SH_VERSION:    exp_sh_version_q    <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // header capture and crc step for the incoming byte
  always_comb begin
    hb_n = hb_q;
    if (pos_q < PosW'(HdrBytes)) begin
      hb_n[pos_q[2:0]] = frame_byte_i;
    end
    shl_n = shl_q;
    if (pos_q == PosW'(6)) begin
      shl_n = {1'b0, frame_byte_i[5:0]} + ShLenW'(1);
    end
    ext_n = ext_q;
    if (pos_q >= PosW'(7) && pos_q <= PosW'(9)) begin
      ext_n = {ext_q[15:0], frame_byte_i};
    end
    crc_n = crc_byte(crc_q, frame_byte_i);
  end

  // classification, checks and result assembly
  always_comb begin
    // effective frame length, saturated
    if (frame_length_q < LenW'(MinFrameBytes)) begin
      len = LenW'(MinFrameBytes);
    end else if (frame_length_q > LenW'(MaxFrameBytes)) begin
      len = LenW'(MaxFrameBytes);
    end else begin
      len = frame_length_q;
    end

    pos12 = LenW'(pos_q);
    ocf   = hb_n[1][0];
    sh    = hb_n[4][7];
    sync  = !hb_n[4][6];
    fecf2 = fecf_enable_q ? LenW'(2) : LenW'(0);
    ocf4  = ocf ? LenW'(4) : LenW'(0);
    last  = (pos12 + LenW'(1)) >= len;

    // primary header first, then trailer, then secondary header
    res = '0;
    res.byte_out = frame_byte_i;
    if (pos12 < LenW'(6)) begin
      res.byte_class = CLS_PRIMARY;
    end else if (fecf_enable_q && pos12 >= len - LenW'(2)) begin
      res.byte_class = CLS_FECF;
    end else if (ocf && pos12 >= len - fecf2 - LenW'(4)) begin
      res.byte_class = CLS_OCF;
    end else if (sh && pos12 < LenW'(6) + LenW'(shl_n)) begin
      res.byte_class = CLS_SECONDARY;
    end else begin
      res.byte_class = CLS_DATA;
    end
    res.frame_end = last;

    // secondary header length bound
    sub = LenW'(MinFrameBytes) + ocf4 + fecf2;
    max_diff = (len < sub) ? '0 : len - sub;
    maxsh = (max_diff > LenW'(MaxShBytes)) ? ShLenW'(MaxShBytes) : max_diff[ShLenW-1:0];
    sh_used = sh ? LenW'(shl_n) : '0;

    // first error wins
    st = ST_OK;
    if (fecf_enable_q && crc_n != 16'h0000) begin
      st = ST_CRC;
    end else if (hb_n[0][7:6] != exp_frame_version_q) begin
      st = ST_VERSION;
    end else if (sh) begin
      if (hb_n[6][7:6] != exp_sh_version_q) begin
        st = ST_SH_VERSION;
      end else if (shl_n > maxsh) begin
        st = ST_SH_TOO_LONG;
      end else if (ext_count_enable_q && shl_n != ShLenW'(4)) begin
        st = ST_EXT_LEN;
      end
    end else if (ext_count_enable_q) begin
      st = ST_EXT_NO_SH;
    end
    if (st == ST_OK && len < sub + sh_used) begin
      st = ST_TOO_SHORT;
    end

    // header fields on the last byte only
    if (last) begin
      res.status        = st;
      res.spacecraft_id = {hb_n[0][5:0], hb_n[1][7:4]};
      res.channel_id    = hb_n[1][3:1];
      res.master_count  = hb_n[2];
      if (ext_count_enable_q && sh && shl_n == ShLenW'(4)) begin
        res.channel_count = {ext_n, hb_n[3]};
      end else begin
        res.channel_count = {24'h0, hb_n[3]};
      end
      res.sh_present        = sh;
      res.byte_synchronised = sync;
      res.header_pointer    = sync ? {hb_n[4][2:0], hb_n[5]} : 11'h000;
      res.ocf_present       = ocf;
    end

    // next position and crc
    if (last) begin
      pos_d = '0;
      crc_d = CrcInit;
    end else begin
      pos_d = PosW'(pos12 + LenW'(1));
      crc_d = crc_n;
    end
  end

  // frame state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      crc_q <= CrcInit;
      shl_q <= '0;
      ext_q <= '0;
      for (int i = 0; i < HdrBytes; i++) begin
        hb_q[i] <= 8'h00;
      end
    end else if (in_acc) begin
      pos_q <= pos_d;
      crc_q <= crc_d;
      shl_q <= shl_n;
      ext_q <= ext_n;
      hb_q  <= hb_n;
    end
  end

  // result register with skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (out_take || !out_valid_q) begin
        out_valid_q  <= skid_valid_q || in_acc;
        skid_valid_q <= 1'b0;
      end else if (in_acc) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (out_take || !out_valid_q) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (in_acc) begin
      skid_q <= res;
    end
  end

  assign in_stall_o          = skid_valid_q;
  assign out_valid_o         = out_valid_q;
  assign byte_out_o          = out_q.byte_out;
  assign byte_class_o        = out_q.byte_class;
  assign frame_end_o         = out_q.frame_end;
  assign status_o            = out_q.status;
  assign spacecraft_id_o     = out_q.spacecraft_id;
  assign channel_id_o        = out_q.channel_id;
  assign master_count_o      = out_q.master_count;
  assign channel_count_o     = out_q.channel_count;
  assign sh_present_o        = out_q.sh_present;
  assign byte_synchronised_o = out_q.byte_synchronised;
  assign header_pointer_o    = out_q.header_pointer;
  assign ocf_present_o       = out_q.ocf_present;

  // skid holds a request only behind a full output register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid full while output register empty");

  // last byte of a frame restarts position and crc
  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && last) |=> (pos_q == '0 && crc_q == CrcInit))
    else $error("frame state not restarted after last byte");

  // a status is only reported on a frame end
  a_status_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.frame_end) |-> (out_q.status == ST_OK))
    else $error("status reported on a byte that does not end a frame");

  // a stalled request is not lost: output request stays while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> out_valid_q)
    else $error("output request dropped under stall");

endmodule
